// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the Hilbert analytic-signal core.
// Every macro assumes a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fhas_pkg.sv
// Package for the frame-based Hilbert analytic-signal core: sizes, types and
// the elaboration-time Hilbert kernel table. No dependencies.
`default_nettype none

package fhas_pkg;

    localparam int FRAME_LEN = 64;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int ADDR_W    = IDX_W + 1;             // bank bit plus index
    localparam int RAM_DEPTH = 2 * FRAME_LEN;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;                    // signed Q1.17
    localparam int COEF_FRAC = 17;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int COEF_CNT  = FRAME_LEN / 4 + 1;     // odd taps 1..N/2-1, plus N/2
    localparam int CI_W      = IDX_W - 1;
    localparam int S_TDATA_W = SAMPLE_W;
    localparam int M_TDATA_W = 2 * SAMPLE_W;

    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;
    localparam logic [63:0] ONE_Q62      = 64'h4000000000000000;
    localparam logic [63:0] PI_STEP      = PI_Q62 / FRAME_LEN;
    localparam logic [63:0] PI_REM       = PI_Q62 % FRAME_LEN;
    localparam int          TAYLOR_TERMS = 25;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-(2 ** (SAMPLE_W - 1)));

    typedef logic [COEF_CNT-1:0][COEF_W-1:0] t_coef_tab;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Per-cycle command from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic             clear;
        logic             issue;
        logic             hit;
        logic [IDX_W-1:0] tap;
    } t_mac_ctrl;

    // Status and results returned by the multiply-accumulate unit.
    typedef struct packed {
        logic                       busy;
        logic signed [ACC_W-1:0]    acc;
        logic signed [SAMPLE_W-1:0] re_val;
    } t_mac_stat;

    // Unsigned Q2.62 product, floor(a*b / 2^62) kept to 64 bits.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Kernel magnitudes round(2^18 * cos / (N * sin)) for odd taps, evaluated
    // once at elaboration from Taylor series in Q2.62.
    function automatic t_coef_tab build_coef_tab();
        t_coef_tab    tab;
        logic [63:0]  x, x2, ts, tc, ss, sc, num, den, lim, res, cand;
        logic [127:0] trial;
        tab = '0;
        for (int m = 1; m < FRAME_LEN / 2; m += 2) begin
            x  = PI_STEP * 64'(m) + (PI_REM * 64'(m)) / FRAME_LEN;
            x2 = mul_q62(x, x);
            ts = x;
            tc = ONE_Q62;
            ss = x;
            sc = ONE_Q62;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
                tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
                if ((k & 1) != 0) begin
                    ss = ss - ts;
                    sc = sc - tc;
                end else begin
                    ss = ss + ts;
                    sc = sc + tc;
                end
            end
            num = (sc >> 20) << 18;
            den = 64'(FRAME_LEN) * (ss >> 20);
            if (den == 64'd0) begin
                den = 64'd1;
            end
            lim = num + (den >> 1);
            res = '0;
            // Largest quotient with quotient * den <= lim, one bit at a time.
            for (int b = COEF_W - 2; b >= 0; b--) begin
                cand  = res | (64'd1 << b);
                trial = {64'd0, cand} * {64'd0, den};
                if (trial <= {64'd0, lim}) begin
                    res = cand;
                end
            end
            tab[m >> 1] = res[COEF_W-1:0];
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_TAB = build_coef_tab();

endpackage

`default_nettype wire

// File: rtl/fhas_ram.sv
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No package dependencies.
`default_nettype none

module fhas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/fhas_mac.sv
// Multiply-accumulate unit of the Hilbert core: kernel lookup, one signed
// 16x18 product per cycle and an exact accumulator. Depends on fhas_pkg.
`default_nettype none

module fhas_mac (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fhas_pkg::t_mac_ctrl            i_ctrl,
    input  wire logic [fhas_pkg::SAMPLE_W-1:0]  i_rdata,
    output fhas_pkg::t_mac_stat                 o_stat
);
    import fhas_pkg::*;

    logic [IDX_W-1:0]           tap_abs;
    logic [CI_W-1:0]            tap_sel;
    logic signed [COEF_W-1:0]   coef_mag;
    logic signed [COEF_W-1:0]   coef_sel;

    logic                       r_v1;
    logic                       r_hit1;
    logic signed [COEF_W-1:0]   r_coef1;
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_re;

    // Tap m and N-m share a magnitude; the upper half takes the negative.
    always_comb begin
        tap_abs  = i_ctrl.tap[IDX_W-1] ? (~i_ctrl.tap + IDX_W'(1)) : i_ctrl.tap;
        tap_sel  = tap_abs[IDX_W-1:1];
        coef_mag = $signed(COEF_TAB[tap_sel]);
        if (!i_ctrl.tap[0]) begin
            coef_sel = '0;
        end else if (i_ctrl.tap[IDX_W-1]) begin
            coef_sel = -coef_mag;
        end else begin
            coef_sel = coef_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit1  <= i_ctrl.hit;
        r_coef1 <= coef_sel;
        if (r_v1) begin
            r_prod <= $signed(i_rdata) * r_coef1;
        end
        if (r_v1 && r_hit1) begin
            r_re <= $signed(i_rdata);
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{IDX_W{r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_stat.busy   = r_v1 | r_v2;
    assign o_stat.acc    = r_acc;
    assign o_stat.re_val = r_re;

endmodule

`default_nettype wire

// File: rtl/frame_hilbert_analytic_signal_core.sv
// Top level of the frame-based Hilbert analytic-signal core. Depends on
// fhas_pkg, fhas_ram, fhas_mac and assert_macros.svh.
//
//   Channel | Dir | Signals                         | Payload
//   --------+-----+---------------------------------+--------------------------------
//   s       | in  | i_s_tvalid, o_s_tready, tdata   | sample
//   m       | out | o_m_tvalid, i_m_tready, tdata,  | real_part, imag_part,
//           |     | tlast                           | frame_last on tlast
//
// Each transaction accepts one sample, then reads every sample of the previous frame
// through the single read port of the sample RAM, each read feeding one multiply-accumulate,
// then drains the MAC pipeline and loads the output register. A stalled output register
// delays that last load.
// Reset is synchronous and active low; it clears control state only and needs no
// clearing pass, since results before the first complete frame are forced to zero.
`default_nettype none
`include "assert_macros.svh"

module frame_hilbert_analytic_signal_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [fhas_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [15:0] sample
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [fhas_pkg::M_TDATA_W-1:0]  o_m_tdata,   // [15:0] real_part,
                                                              // [31:16] imag_part
    output logic                                 o_m_tlast    // frame_last
);
    import fhas_pkg::*;

    // The sample RAM holds two frames. The bank selected by r_bank is being filled
    // by incoming samples; the other bank holds the previous complete frame, which
    // every transaction convolves with the Hilbert kernel at its own index. Writes
    // and reads always fall in different banks, so no forwarding is needed.

    t_state                     r_state;
    t_state                     n_state;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_n;
    logic                       r_bank;
    logic                       r_have_frame;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_real;
    logic signed [SAMPLE_W-1:0] r_out_imag;
    logic                       r_out_last;

    logic                       s_accept;
    logic                       out_free;
    logic                       load;
    logic                       idx_last;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    t_mac_ctrl                  mac_ctrl;
    t_mac_stat                  mac_stat;

    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [ACC_W-1:0]    rnd_q;
    logic signed [SAMPLE_W-1:0] rnd_imag;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign idx_last   = (r_idx == IDX_W'(FRAME_LEN - 1));
    assign load       = (r_state == ST_DONE) && !mac_stat.busy && out_free;

    assign ram_waddr = {r_bank, r_idx};
    assign ram_raddr = {~r_bank, r_n};

    fhas_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_tdata[SAMPLE_W-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The kernel tap for stored sample n at output index k is (k - n) mod N.
    always_comb begin
        mac_ctrl.clear = s_accept;
        mac_ctrl.issue = (r_state == ST_RUN);
        mac_ctrl.hit   = (r_n == r_idx);
        mac_ctrl.tap   = r_idx - r_n;
    end

    fhas_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_rdata (ram_rdata),
        .o_stat  (mac_stat)
    );

    // Round half up at bit 17, then saturate to the 16-bit range.
    always_comb begin
        rnd_sum = mac_stat.acc + RND_HALF;
        rnd_q   = rnd_sum >>> COEF_FRAC;
        if (rnd_q > SAT_HI) begin
            rnd_imag = SAT_HI[SAMPLE_W-1:0];
        end else if (rnd_q < SAT_LO) begin
            rnd_imag = SAT_LO[SAMPLE_W-1:0];
        end else begin
            rnd_imag = rnd_q[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_n == IDX_W'(FRAME_LEN - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_n          <= '0;
            r_bank       <= 1'b0;
            r_have_frame <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_n <= '0;
            end else if (r_state == ST_RUN) begin
                r_n <= r_n + IDX_W'(1);
            end
            if (load) begin
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
                if (idx_last) begin
                    r_bank       <= ~r_bank;
                    r_have_frame <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; results before the first full frame read as zero.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_real <= r_have_frame ? mac_stat.re_val : '0;
            r_out_imag <= r_have_frame ? rnd_imag : '0;
            r_out_last <= idx_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_imag, r_out_real};
    assign o_m_tlast  = r_out_last;

    `ASSERT_IMPLY(a_accept_mac_idle, s_accept, !mac_stat.busy, "input taken while MAC busy")
    `ASSERT_NEXT(a_idx_step, load, r_idx == $past(r_idx) + IDX_W'(1), "sample index skipped")
    `ASSERT_IMPLY(a_bank_flip, $rose(r_have_frame), r_bank != $past(r_bank), "no bank swap")
    `ASSERT_IMPLY(a_load_drained, load, r_state == ST_DONE && !mac_stat.busy, "early load")

endmodule

`default_nettype wire
